FILE: sv/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned ITEM_BITS    = 32;
  localparam int unsigned POS_BITS     = 7;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned LEN_OUT_BITS = 7;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_GET    = 2'd3
  } req_e;

  typedef struct packed {
    req_e                  req_type;
    logic [POS_BITS-1:0]   position;
    logic [WORD_BITS-1:0]  item_in;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic [WORD_BITS-1:0]     item_out;
    logic [LEN_OUT_BITS-1:0]  length_out;
    logic                     is_empty;
  } res_t;

endpackage

FILE: sv/ple_mem.sv
// Entry store: single write port, single read port, registered read data.
module ple_mem #(
  parameter int unsigned DEPTH = ple_pkg::CAPACITY,
  parameter int unsigned WIDTH = ple_pkg::ITEM_BITS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: sv/positional_list_engine_core.sv
// Top level of the positional list engine: request sequencer and length register.
//
// Usage
//   Requests enter on req_i and are taken at a rising edge where start is high
//   and busy is low. Each request gives exactly one result beat on res_o, shown
//   for one cycle with done_o high; the receiver cannot hold it off, so capture
//   it on that edge. busy falls in the same cycle as done_o, so a new request
//   may follow straight away.
//   Steps from the accepting edge to the result beat: an append or a refused
//   request is settled in the check state; a get also waits for the registered
//   read; a remove at the last position needs no move; an insert or a remove
//   moving n entries takes a read state and a write state per entry, and an
//   insert then writes the new word into its slot in a state of its own.
//   The shifting of entries sets the rate: each moved entry costs one read and
//   one write on the store, so a worst case insert at the head of a list of
//   CAPACITY-1 entries moves every entry in it.
//   Reset clears the length to zero and returns the sequencer to idle; entry
//   contents are left as they are, since only slots below the length are read.
//   The store needs no clearing pass.
module positional_list_engine_core #(
  parameter int unsigned CAPACITY  = ple_pkg::CAPACITY,
  parameter int unsigned ITEM_BITS = ple_pkg::ITEM_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ple_pkg::req_t req_i,
  output logic          done_o,
  output ple_pkg::res_t res_o
);

  localparam int unsigned AddrW  = $clog2(CAPACITY);
  localparam int unsigned LenW   = $clog2(CAPACITY + 1);
  localparam int unsigned PosW   = ple_pkg::POS_BITS;
  localparam int unsigned WordW  = ple_pkg::WORD_BITS;
  localparam int unsigned LenOutW = ple_pkg::LEN_OUT_BITS;
  localparam int unsigned CmpW   = (LenW > PosW) ? LenW : PosW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MV_RD,
    ST_MV_WR,
    ST_INS_PUT,
    ST_GET_WAIT
  } state_e;

  state_e         state_q;
  ple_pkg::req_t  req_q;
  logic [LenW-1:0]  len_q;
  logic [AddrW-1:0] k_q;
  logic           done_q;
  ple_pkg::res_t  res_q;

  // Request decode
  logic             pos_ok;
  logic             full;
  logic [PosW-1:0]  slot_p;
  logic [AddrW-1:0] slot;
  logic [AddrW-1:0] last;
  logic [LenW-1:0]  len_inc;
  logic [LenW-1:0]  len_dec;

  // Store port
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic [ITEM_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AddrW-1:0]     mem_raddr;
  logic [ITEM_BITS-1:0] mem_rdata;

  assign pos_ok  = (req_q.position != '0) && (CmpW'(req_q.position) <= CmpW'(len_q));
  assign full    = (CmpW'(len_q) == CmpW'(CAPACITY));
  assign slot_p  = req_q.position - PosW'(1);
  assign slot    = AddrW'(slot_p);
  assign len_inc = len_q + LenW'(1);
  assign len_dec = len_q - LenW'(1);
  assign last    = AddrW'(len_dec);

  // Build a result beat; item is zero except for a good get.
  function automatic ple_pkg::res_t make_res(logic ok, logic [WordW-1:0] item,
                                             logic [LenW-1:0] len);
    ple_pkg::res_t r;
    r.ok         = ok;
    r.item_out   = item;
    r.length_out = LenOutW'(len);
    r.is_empty   = (len == '0);
    return r;
  endfunction

  // Store control: append writes at the tail, a get reads its slot, a move reads
  // then writes one slot over, the insert ends by dropping the new word into its slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = ITEM_BITS'(req_q.item_in);
    mem_re    = 1'b0;
    mem_raddr = k_q;
    case (state_q)
      ST_CHECK: begin
        if (req_q.req_type == ple_pkg::REQ_APPEND && !full) begin
          mem_we    = 1'b1;
          mem_waddr = AddrW'(len_q);
        end
        if (req_q.req_type == ple_pkg::REQ_GET && pos_ok) begin
          mem_re    = 1'b1;
          mem_raddr = slot;
        end
      end
      ST_MV_RD: begin
        mem_re = 1'b1;
      end
      ST_MV_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (req_q.req_type == ple_pkg::REQ_INSERT) begin
          mem_waddr = k_q + AddrW'(1);
        end else begin
          mem_waddr = k_q - AddrW'(1);
        end
      end
      ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = slot;
      end
      default: begin
      end
    endcase
  end

  ple_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ITEM_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer, length register and result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
      req_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            req_q   <= req_i;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          case (req_q.req_type)
            ple_pkg::REQ_APPEND: begin
              // Write issued this cycle by the store control.
              if (!full) begin
                len_q <= len_inc;
                res_q <= make_res(1'b1, '0, len_inc);
              end else begin
                res_q <= make_res(1'b0, '0, len_q);
              end
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
            ple_pkg::REQ_INSERT: begin
              if (pos_ok && !full) begin
                // Move from the tail down to the target slot.
                k_q     <= last;
                done_q  <= 1'b0;
                state_q <= ST_MV_RD;
              end else begin
                res_q   <= make_res(1'b0, '0, len_q);
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
            end
            ple_pkg::REQ_REMOVE: begin
              if (!pos_ok) begin
                res_q   <= make_res(1'b0, '0, len_q);
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end else if (slot == last) begin
                // Tail removal: nothing to close up.
                len_q   <= len_dec;
                res_q   <= make_res(1'b1, '0, len_dec);
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end else begin
                k_q     <= slot + AddrW'(1);
                done_q  <= 1'b0;
                state_q <= ST_MV_RD;
              end
            end
            ple_pkg::REQ_GET: begin
              if (pos_ok) begin
                done_q  <= 1'b0;
                state_q <= ST_GET_WAIT;
              end else begin
                res_q   <= make_res(1'b0, '0, len_q);
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
            end
            default: begin
              done_q  <= 1'b0;
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_MV_RD: begin
          done_q  <= 1'b0;
          state_q <= ST_MV_WR;
        end
        ST_MV_WR: begin
          if (req_q.req_type == ple_pkg::REQ_INSERT) begin
            done_q <= 1'b0;
            if (k_q == slot) begin
              state_q <= ST_INS_PUT;
            end else begin
              k_q     <= k_q - AddrW'(1);
              state_q <= ST_MV_RD;
            end
          end else begin
            if (k_q == last) begin
              len_q   <= len_dec;
              res_q   <= make_res(1'b1, '0, len_dec);
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + AddrW'(1);
              done_q  <= 1'b0;
              state_q <= ST_MV_RD;
            end
          end
        end
        ST_INS_PUT: begin
          len_q   <= len_inc;
          res_q   <= make_res(1'b1, '0, len_inc);
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_GET_WAIT: begin
          res_q   <= make_res(1'b1, WordW'(mem_rdata), len_q);
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: sim/positional_list_engine_core_tb.sv
// Self-checking testbench for the positional list engine: directed table, then random phases.
`timescale 1ns / 1ps

module positional_list_engine_core_tb;

  // Cycles without any beat moving before the run is declared hung. The slowest
  // request shifts CAPACITY-1 entries, a read and a write each, and the sender may
  // add its longest gap on top, so this leaves a wide margin.
  localparam int unsigned HANG_LIMIT   = 2000;
  // Cycles to watch for stray result beats once nothing is pending.
  localparam int unsigned TAIL_CYCLES  = 4 * ple_pkg::CAPACITY + 16;
  localparam int unsigned RANDOM_BEATS = 1500;

  typedef enum int unsigned {
    PH_GROW,
    PH_SHRINK,
    PH_MIX
  } phase_e;

  typedef struct {
    ple_pkg::req_t beat;
    bit            pinned;
    ple_pkg::res_t want;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  ple_pkg::req_t req_i;
  logic          done_o;
  ple_pkg::res_t res_o;

  // Predictor state: its own copy of the list and of its length.
  logic [ple_pkg::ITEM_BITS-1:0] list_words [ple_pkg::CAPACITY];
  int unsigned                   list_len;

  ple_pkg::res_t pending_results [$];
  row_t          stim_table [$];
  bit            pin_valid;
  ple_pkg::res_t pin_result;
  int unsigned   mismatch_count;
  int unsigned   result_count;
  int unsigned   idle_cycles;

  positional_list_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
    mismatch_count++;
    $display("mismatch at result beat %0d: %s expected 0x%0h got 0x%0h",
             result_count, what, want, seen);
  endtask

  // Apply one request to the predicted list and return the result beat it causes.
  function automatic ple_pkg::res_t list_apply(input ple_pkg::req_t r);
    ple_pkg::res_t o;
    int unsigned   slot;
    int unsigned   k;
    bit            pos_ok;
    o      = '0;
    pos_ok = (r.position >= 1) && (r.position <= list_len);
    slot   = (r.position == 0) ? 0 : r.position - 1;
    case (r.req_type)
      ple_pkg::REQ_APPEND: begin
        if (list_len < ple_pkg::CAPACITY) begin
          list_words[list_len] = r.item_in[ple_pkg::ITEM_BITS-1:0];
          list_len++;
          o.ok = 1'b1;
        end
      end
      ple_pkg::REQ_INSERT: begin
        if (pos_ok && list_len < ple_pkg::CAPACITY) begin
          // Open a hole at the slot by moving the tail up one place.
          for (k = list_len; k > slot; k--) list_words[k] = list_words[k-1];
          list_words[slot] = r.item_in[ple_pkg::ITEM_BITS-1:0];
          list_len++;
          o.ok = 1'b1;
        end
      end
      ple_pkg::REQ_REMOVE: begin
        if (pos_ok) begin
          // Close the gap by moving the tail down one place.
          for (k = slot; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
          o.ok = 1'b1;
        end
      end
      default: begin
        if (pos_ok) begin
          o.item_out = ple_pkg::WORD_BITS'(list_words[slot]);
          o.ok       = 1'b1;
        end
      end
    endcase
    o.length_out = ple_pkg::LEN_OUT_BITS'(list_len);
    o.is_empty   = (list_len == 0);
    return o;
  endfunction

  task automatic add_row(input ple_pkg::req_e kind,
                         input logic [ple_pkg::POS_BITS-1:0] pos,
                         input logic [ple_pkg::WORD_BITS-1:0] word, input bit pinned,
                         input logic ok, input logic [ple_pkg::LEN_OUT_BITS-1:0] len,
                         input logic empty);
    row_t row;
    row.beat.req_type  = kind;
    row.beat.position  = pos;
    row.beat.item_in   = word;
    row.pinned         = pinned;
    row.want.ok        = ok;
    row.want.item_out  = '0;
    row.want.length_out = len;
    row.want.is_empty  = empty;
    stim_table.push_back(row);
  endtask

  // Sender gap: mostly none, some short, a few long; none at all in quiet phases.
  function automatic int unsigned pick_gap(input bit idle_on);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Draw a request with its position mostly inside the current list, so that
  // shifts of every length happen, and now and then off the end or anywhere.
  function automatic ple_pkg::req_t pick_request(input phase_e phase);
    ple_pkg::req_t r;
    int unsigned   roll;
    roll = $urandom_range(0, 99);
    case (phase)
      PH_GROW:   r.req_type = (roll < 50) ? ple_pkg::REQ_APPEND :
                              (roll < 80) ? ple_pkg::REQ_INSERT :
                              (roll < 90) ? ple_pkg::REQ_GET : ple_pkg::REQ_REMOVE;
      PH_SHRINK: r.req_type = (roll < 10) ? ple_pkg::REQ_APPEND :
                              (roll < 20) ? ple_pkg::REQ_INSERT :
                              (roll < 40) ? ple_pkg::REQ_GET : ple_pkg::REQ_REMOVE;
      default:   r.req_type = ple_pkg::req_e'(roll[1:0]);
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 80)
      r.position = (list_len == 0) ? ple_pkg::POS_BITS'(1) :
                   ple_pkg::POS_BITS'($urandom_range(1, list_len));
    else if (roll < 90)
      r.position = $urandom_range(0, 1) ? ple_pkg::POS_BITS'(list_len + 1) : '0;
    else
      r.position = ple_pkg::POS_BITS'($urandom_range(0, 127));
    roll = $urandom_range(0, 99);
    r.item_in = (roll < 10) ? '1 : (roll < 20) ? '0 : ple_pkg::WORD_BITS'($urandom);
    return r;
  endfunction

  // Present one request beat and hold it until the block takes it.
  task automatic send_beat(input ple_pkg::req_t beat, input bit pinned,
                           input ple_pkg::res_t want, input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pin_valid  = pinned;
    pin_result = want;
    start <= 1'b1;
    req_i <= beat;
    do @(posedge clk_i); while (busy);
  endtask

  // Monitor: check result beats against the oldest expectation, then predict
  // for a request beat taken on the same edge. Also watch for a hang.
  always @(posedge clk_i) begin
    ple_pkg::res_t want;
    ple_pkg::res_t got;
    if (rst_ni) begin
      if (done_o) begin
        got = res_o;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending, item_out", '0, got.item_out);
        end else begin
          want = pending_results.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", 32'(want.ok), 32'(got.ok));
          if (got.item_out !== want.item_out)
            report_mismatch("item_out", want.item_out, got.item_out);
          if (got.length_out !== want.length_out)
            report_mismatch("length_out", 32'(want.length_out), 32'(got.length_out));
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        end
        result_count++;
      end
      if (start && !busy) begin
        // Advance the predictor in any case; a pinned row overrides its answer.
        want = list_apply(req_i);
        pending_results.push_back(pin_valid ? pin_result : want);
      end
      if (done_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", HANG_LIMIT);
        $display("positional_list_engine_core_tb failed");
        $finish;
      end
    end
  end

  initial begin
    phase_e        phase;
    bit            idle_on;
    int unsigned   phase_len;
    int unsigned   sent;
    ple_pkg::res_t no_pin;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    pin_valid      = 1'b0;
    pin_result     = '0;
    no_pin         = '0;
    list_len       = 0;
    mismatch_count = 0;
    result_count   = 0;
    idle_cycles    = 0;
    sent           = 0;

    // Directed table. Rows with pinned results are read straight off the rules:
    // empty list, bad positions (zero, past the end, insert at length plus one),
    // appends ignoring the position, and the remove that empties the list.
    add_row(ple_pkg::REQ_GET,    7'd1,   32'h0,        1, 1'b0, 7'd0, 1'b1);
    add_row(ple_pkg::REQ_REMOVE, 7'd1,   32'h0,        1, 1'b0, 7'd0, 1'b1);
    add_row(ple_pkg::REQ_INSERT, 7'd1,   32'h12345678, 1, 1'b0, 7'd0, 1'b1);
    add_row(ple_pkg::REQ_GET,    7'd0,   32'h0,        1, 1'b0, 7'd0, 1'b1);
    add_row(ple_pkg::REQ_APPEND, 7'd127, 32'hFFFFFFFF, 1, 1'b1, 7'd1, 1'b0);
    add_row(ple_pkg::REQ_APPEND, 7'd0,   32'h0,        1, 1'b1, 7'd2, 1'b0);
    add_row(ple_pkg::REQ_GET,    7'd1,   32'h0,        0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_GET,    7'd2,   32'h0,        0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_GET,    7'd3,   32'h0,        1, 1'b0, 7'd2, 1'b0);
    add_row(ple_pkg::REQ_INSERT, 7'd1,   32'hA5A5A5A5, 0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_INSERT, 7'd3,   32'h5A5A5A5A, 0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_INSERT, 7'd5,   32'hDEADBEEF, 1, 1'b0, 7'd4, 1'b0);
    add_row(ple_pkg::REQ_GET,    7'd127, 32'h0,        1, 1'b0, 7'd4, 1'b0);
    add_row(ple_pkg::REQ_REMOVE, 7'd0,   32'h0,        1, 1'b0, 7'd4, 1'b0);
    add_row(ple_pkg::REQ_REMOVE, 7'd4,   32'h0,        0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_REMOVE, 7'd1,   32'h0,        0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_GET,    7'd1,   32'h0,        0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_GET,    7'd2,   32'h0,        0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_APPEND, 7'd64,  32'h80000001, 0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_REMOVE, 7'd5,   32'h0,        1, 1'b0, 7'd3, 1'b0);
    add_row(ple_pkg::REQ_REMOVE, 7'd2,   32'h0,        0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_REMOVE, 7'd1,   32'h0,        0, 1'b0, 7'd0, 1'b0);
    add_row(ple_pkg::REQ_REMOVE, 7'd1,   32'h0,        1, 1'b1, 7'd0, 1'b1);
    add_row(ple_pkg::REQ_GET,    7'd1,   32'h0,        1, 1'b0, 7'd0, 1'b1);

    // Hold reset, then release it away from the rising edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[i])
      send_beat(stim_table[i].beat, stim_table[i].pinned, stim_table[i].want,
                pick_gap(1'b1));

    // Random phases: growth runs long enough to fill the list and hit the
    // refusals when full, shrink runs drain it, mixed runs stir it up.
    while (sent < RANDOM_BEATS) begin
      phase     = phase_e'($urandom_range(0, 2));
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_len = (phase == PH_MIX) ? $urandom_range(20, 60) : $urandom_range(60, 140);
      repeat (phase_len) begin
        send_beat(pick_request(phase), 1'b0, no_pin, pick_gap(idle_on));
        sent++;
      end
    end

    @(negedge clk_i);
    start <= 1'b0;

    // Drain: the hang watchdog covers a result that never comes.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("positional_list_engine_core_tb passed");
    end else begin
      $display("positional_list_engine_core_tb failed");
    end
    $finish;
  end

endmodule
